FILE: sv/fdrsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrsu_pkg
// shared constants and types for the step-up false discovery rate test
// ----------------------------------------------------------------------------
package fdrsu_pkg;

	localparam int MAX_CHANNELS = 32;
	localparam int CH_W         = $clog2(MAX_CHANNELS);
	localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
	localparam int P_W          = 33;
	localparam int LEVEL_W      = 32;
	localparam int PROD_W       = P_W + CNT_W;
	localparam int ATTR_W       = 5;
	localparam int USED_W       = 6;

	localparam logic [LEVEL_W-1:0] FDR_LEVEL_RESET = 32'd214748365;

	typedef struct packed {
		logic [P_W-1:0]  pval;
		logic [CH_W-1:0] chan;
	} entry_t;

endpackage

FILE: sv/fdr_step_up_reject.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdr_step_up_reject
// step-up (benjamini-hochberg) rejection over one set of channel p-values
// ----------------------------------------------------------------------------
// Channels arrive one per transfer; present p-values are kept in ascending
// order (ties in arrival order) in a single one-port-read memory. An absent
// channel, or any channel beyond MAX_CHANNELS, is not stored. A present
// channel is inserted by walking down the memory one read and one write at
// a time, moving each stored entry larger than it up by one; when it lands
// at the front of the order (first present channel of a set, or smaller
// than every stored value), it is written at position 0 without a read.
// The last item then starts a rank scan over the present channels (one
// memory read per rank, a product stage and a compare); an empty set
// skips the scan. The result sits in an output register, so the next set
// may start while it waits to be taken; a second result waits for the
// first to leave. fdr_level is taken from its own write channel, always
// ready.
// ----------------------------------------------------------------------------
module fdr_step_up_reject (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fdrsu_pkg::LEVEL_W-1:0]   fdr_level,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [fdrsu_pkg::P_W-1:0]       p_value,
	input  logic                            present,
	input  logic                            last_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            reject,
	output logic                            attr_valid,
	output logic [fdrsu_pkg::ATTR_W-1:0]    attr_channel,
	output logic [fdrsu_pkg::USED_W-1:0]    used_count
);
	import fdrsu_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [CNT_W-1:0]     arrival_q;
	logic [CNT_W-1:0]     present_q;
	logic [CNT_W-1:0]     pos_q;
	logic [CNT_W-1:0]     k_q;
	logic                 last_q;
	entry_t               ins_q;
	logic                 hit_q;
	logic [CH_W-1:0]      attr_q;

	entry_t               mem [MAX_CHANNELS];
	entry_t               rd_q;
	logic                 mem_re;
	logic [CH_W-1:0]      mem_raddr;
	logic                 mem_we;
	logic [CH_W-1:0]      mem_waddr;
	entry_t               mem_wdata;

	logic                 valid_s1;
	logic                 first_s1;
	logic [CNT_W-1:0]     k1_s1;
	logic                 valid_s2;
	logic [PROD_W-1:0]    lhs_s2;
	logic [PROD_W-1:0]    rhs_s2;

	logic                 in_acc;
	logic                 out_load;
	logic                 shift_up;
	logic [CNT_W-1:0]     pos_m1;
	logic [63:0]          attr_wide;
	logic [63:0]          used_wide;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == ST_FINISH) && (!out_valid || !out_stall);
	assign pos_m1    = pos_q - CNT_W'(1);
	assign shift_up  = (rd_q.pval > ins_q.pval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= FDR_LEVEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			level_q <= fdr_level;
		end
	end

	// memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = pos_m1[CH_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = pos_q[CH_W-1:0];
		mem_wdata = ins_q;
		unique case (state_q)
			ST_INS_RD: begin
				if (pos_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
				end
			end
			ST_INS_CMP: begin
				mem_we = 1'b1;
				if (shift_up) begin
					mem_wdata = rd_q;
				end
			end
			ST_SCAN: begin
				mem_re    = 1'b1;
				mem_raddr = k_q[CH_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// scan datapath: read, products, compare
	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		k1_s1    <= k_q + CNT_W'(1);
		lhs_s2   <= PROD_W'(rd_q.pval) * PROD_W'(present_q);
		rhs_s2   <= PROD_W'(level_q) * PROD_W'(k1_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			hit_q    <= 1'b0;
			attr_q   <= '0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			valid_s2 <= valid_s1;
			if (valid_s1 && first_s1) begin
				attr_q <= rd_q.chan;
			end
			if (out_load) begin
				hit_q <= 1'b0;
			end else if (valid_s2 && (lhs_s2 <= rhs_s2)) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign attr_wide = 64'(attr_q);
	assign used_wide = 64'(present_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			arrival_q    <= '0;
			present_q    <= '0;
			pos_q        <= '0;
			k_q          <= '0;
			last_q       <= 1'b0;
			ins_q        <= '0;
			out_valid    <= 1'b0;
			reject       <= 1'b0;
			attr_valid   <= 1'b0;
			attr_channel <= '0;
			used_count   <= '0;
		end else begin
			if (out_valid && !out_stall && !out_load) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= last_item;
						k_q    <= '0;
						if (arrival_q < CNT_W'(MAX_CHANNELS)) begin
							arrival_q <= arrival_q + CNT_W'(1);
						end
						if (arrival_q < CNT_W'(MAX_CHANNELS) && present) begin
							ins_q.pval <= p_value;
							ins_q.chan <= arrival_q[CH_W-1:0];
							pos_q      <= present_q;
							state_q    <= ST_INS_RD;
						end else if (last_item) begin
							state_q <= (present_q == '0) ? ST_FINISH : ST_SCAN;
						end
					end
				end
				ST_INS_RD: begin
					if (pos_q == '0) begin
						present_q <= present_q + CNT_W'(1);
						state_q   <= last_q ? ST_SCAN : ST_IDLE;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (shift_up) begin
						pos_q   <= pos_m1;
						state_q <= ST_INS_RD;
					end else begin
						present_q <= present_q + CNT_W'(1);
						state_q   <= last_q ? ST_SCAN : ST_IDLE;
					end
				end
				ST_SCAN: begin
					k_q <= k_q + CNT_W'(1);
					if (k_q == present_q - CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						out_valid    <= 1'b1;
						reject       <= hit_q;
						attr_valid   <= hit_q;
						attr_channel <= hit_q ? attr_wide[ATTR_W-1:0] : '0;
						used_count   <= used_wide[USED_W-1:0];
						present_q    <= '0;
						arrival_q    <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	a_present_le_arrival: assert property (@(posedge clk) disable iff (!arst_n)
		present_q <= arrival_q)
		else $error("present count exceeds arrival count");

	a_arrival_limit: assert property (@(posedge clk) disable iff (!arst_n)
		arrival_q <= CNT_W'(MAX_CHANNELS))
		else $error("arrival count beyond channel limit");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!valid_s1 && !valid_s2))
		else $error("scan pipeline busy while idle");

	a_reject_needs_channels: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reject) |-> (used_count != '0))
		else $error("reject reported for an empty set");

endmodule
